/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/bld_pkg.sv */
// Shared types, constants and helper functions of the bitplane luma dither block.
`default_nettype none

package bld_pkg;

	localparam int PALETTE_SIZE = 64;
	localparam int BANK_DEPTH   = PALETTE_SIZE / 2;
	localparam int BANK_AW      = $clog2(BANK_DEPTH);
	localparam int IDX_W        = $clog2(PALETTE_SIZE);
	localparam int PIXELS       = 8;
	localparam int PLANES       = 6;
	localparam int ACTIVE_LINES = 256;
	localparam int ACTIVE_WORDS = 40;
	localparam int LINE_OFFSET  = 25;
	localparam int WORD_OFFSET  = 8;
	localparam int LUMA_R_COEF  = 77;
	localparam int LUMA_G_COEF  = 150;
	localparam int LUMA_B_COEF  = 29;
	localparam int QUEUE_DEPTH  = 4;

	typedef enum logic [1:0] {
		CMD_PALETTE = 2'd0,
		CMD_MIRROR  = 2'd1,
		CMD_RENDER  = 2'd2
	} cmd_t;

	// Classified item as it waits between front and back.
	typedef struct packed {
		cmd_t                   op;
		logic [IDX_W-1:0]       index;
		logic [7:0]             luma;
		logic [7:0]             luma_half;
		logic [PLANES-1:0][7:0] planes;
		logic [1:0]             dith_row;
		logic [8:0]             line;
		logic [5:0]             word;
	} item_t;

	// Luma table write, one port per half of the palette.
	typedef struct packed {
		logic               lo_en;
		logic               hi_en;
		logic [BANK_AW-1:0] addr;
		logic [7:0]         lo_data;
		logic [7:0]         hi_data;
	} wr_t;

	// Weighted sum of the three channels, top byte kept.
	function automatic logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		logic [15:0] sum;
		sum = 16'(LUMA_R_COEF) * {8'b0, r} + 16'(LUMA_G_COEF) * {8'b0, g}
			+ 16'(LUMA_B_COEF) * {8'b0, b};
		return sum[15:8];
	endfunction

	// 4x4 ordered dither threshold.
	function automatic logic [3:0] bayer(logic [1:0] r, logic [1:0] c);
		logic [3:0] v;
		unique case ({r, c})
			4'h0: v = 4'd0;
			4'h1: v = 4'd8;
			4'h2: v = 4'd2;
			4'h3: v = 4'd10;
			4'h4: v = 4'd12;
			4'h5: v = 4'd4;
			4'h6: v = 4'd14;
			4'h7: v = 4'd6;
			4'h8: v = 4'd3;
			4'h9: v = 4'd11;
			4'ha: v = 4'd1;
			4'hb: v = 4'd9;
			4'hc: v = 4'd15;
			4'hd: v = 4'd7;
			4'he: v = 4'd13;
			4'hf: v = 4'd5;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* hdl/bitplane_luma_bayer_dither_top.sv */
// Top level of the planar palette to dithered grey converter.
// Input channel (in_valid / in_stall): one command per item. Palette writes
// (command 0, and command 1 with its half-bright mirror) update the luma table
// and give no result. A render (command 2) turns six bitplane bytes into one
// 32-bit word of eight dithered grey nibbles with its line and word position.
// Renders outside the active area and the unused command code are dropped.
// Output channel (out_valid / out_stall): one item per render, in order.
// Throughput is one item per cycle while the output is not stalled; each pixel
// lane owns a copy of the luma table, so all eight lookups share one cycle. A
// render passes through the queue, the lookup registers and the output register;
// it sees every table write accepted before it.
// A stalled result holds on the outputs; the back end stops with it, and the
// four-entry queue keeps taking items until it fills, then raises in_stall.
// Reset clears the queue, the pipeline valid flags and the table's written flags,
// so every entry reads as zero until written; the block is ready once reset ends.
`default_nettype none

module bitplane_luma_bayer_dither_top #(
	parameter int QUEUE_DEPTH = bld_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [5:0]  entry_index,
	input  wire logic [23:0] color_value,
	input  wire logic [7:0]  plane0_byte,
	input  wire logic [7:0]  plane1_byte,
	input  wire logic [7:0]  plane2_byte,
	input  wire logic [7:0]  plane3_byte,
	input  wire logic [7:0]  plane4_byte,
	input  wire logic [7:0]  plane5_byte,
	input  wire logic [7:0]  row,
	input  wire logic [5:0]  column,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      pixel_word,
	output logic [8:0]       line_number,
	output logic [5:0]       word_number
);

	bld_pkg::item_t front_item;
	bld_pkg::item_t head_item;
	logic           keep;
	logic           q_full;
	logic           q_valid;
	logic           pop;
	logic           push;

	// Accept an item whenever the queue has room.
	assign in_stall = q_full;
	assign push     = in_valid && !q_full && keep;

	bld_front u_front (
		.command     (command),
		.entry_index (entry_index),
		.color_value (color_value),
		.plane0_byte (plane0_byte),
		.plane1_byte (plane1_byte),
		.plane2_byte (plane2_byte),
		.plane3_byte (plane3_byte),
		.plane4_byte (plane4_byte),
		.plane5_byte (plane5_byte),
		.row         (row),
		.column      (column),
		.item        (front_item),
		.keep        (keep)
	);

	bld_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head_item (head_item),
		.not_empty (q_valid),
		.full      (q_full)
	);

	bld_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.head        (head_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_word  (pixel_word),
		.line_number (line_number),
		.word_number (word_number)
	);

endmodule

`default_nettype wire

/* hdl/bld_front.sv */
// Front end: classify incoming items, compute luma values and frame positions.
`default_nettype none

module bld_front (
	input  wire logic [1:0]  command,
	input  wire logic [5:0]  entry_index,
	input  wire logic [23:0] color_value,
	input  wire logic [7:0]  plane0_byte,
	input  wire logic [7:0]  plane1_byte,
	input  wire logic [7:0]  plane2_byte,
	input  wire logic [7:0]  plane3_byte,
	input  wire logic [7:0]  plane4_byte,
	input  wire logic [7:0]  plane5_byte,
	input  wire logic [7:0]  row,
	input  wire logic [5:0]  column,
	output bld_pkg::item_t   item,
	output logic             keep
);

	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       in_frame;

	assign red   = color_value[23:16];
	assign green = color_value[15:8];
	assign blue  = color_value[7:0];

	// Drop renders that fall outside the active area.
	assign in_frame = (32'(row) < 32'(bld_pkg::ACTIVE_LINES))
		&& (32'(column) < 32'(bld_pkg::ACTIVE_WORDS));

	// Decide which items go on to the back end.
	always_comb begin
		unique case (bld_pkg::cmd_t'(command))
			bld_pkg::CMD_PALETTE: keep = 1'b1;
			bld_pkg::CMD_MIRROR:  keep = 1'b1;
			bld_pkg::CMD_RENDER:  keep = in_frame;
			default:              keep = 1'b0;
		endcase
	end

	// Build the queued item.
	always_comb begin
		item.op        = bld_pkg::cmd_t'(command);
		item.index     = entry_index;
		item.luma      = bld_pkg::luma_of(red, green, blue);
		item.luma_half = bld_pkg::luma_of({1'b0, red[7:1]}, {1'b0, green[7:1]},
			{1'b0, blue[7:1]});
		item.planes    = {plane5_byte, plane4_byte, plane3_byte,
			plane2_byte, plane1_byte, plane0_byte};
		item.dith_row  = row[1:0];
		item.line      = 9'(row) + 9'(bld_pkg::LINE_OFFSET);
		item.word      = column + 6'(bld_pkg::WORD_OFFSET);
	end

endmodule

`default_nettype wire

/* hdl/bld_queue.sv */
// Short item queue between the front and back ends.
`default_nettype none

module bld_queue #(
	parameter int DEPTH = bld_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire bld_pkg::item_t push_item,
	input  wire logic           pop,
	output bld_pkg::item_t      head_item,
	output logic                not_empty,
	output logic                full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bld_pkg::item_t store_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign head_item = store_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));

	// Hold item payloads.
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and the fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/bld_lane.sv */
// One pixel lane: private copy of the luma table and the dither quantizer.
`default_nettype none

module bld_lane (
	input  wire logic                      clk,
	input  wire logic                      rd_en,
	input  wire logic [bld_pkg::IDX_W-1:0] rd_index,
	input  wire bld_pkg::wr_t              wr,
	input  wire logic                      known_s1,
	input  wire logic [3:0]                dither,
	output logic [3:0]                     nibble
);

	logic [7:0] lo_mem [bld_pkg::BANK_DEPTH];
	logic [7:0] hi_mem [bld_pkg::BANK_DEPTH];
	logic [7:0] lo_s1;
	logic [7:0] hi_s1;
	logic       bank_s1;
	logic [7:0] luma;
	logic [7:0] sum;
	logic [2:0] level;

	// Write both halves of the table.
	always_ff @(posedge clk) begin
		if (wr.lo_en) begin
			lo_mem[wr.addr] <= wr.lo_data;
		end
		if (wr.hi_en) begin
			hi_mem[wr.addr] <= wr.hi_data;
		end
	end

	// Read both halves at the pixel's entry.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			lo_s1   <= lo_mem[rd_index[bld_pkg::BANK_AW-1:0]];
			hi_s1   <= hi_mem[rd_index[bld_pkg::BANK_AW-1:0]];
			bank_s1 <= rd_index[bld_pkg::IDX_W-1];
		end
	end

	// Pick the half, treat unwritten entries as zero, dither and clamp.
	always_comb begin
		luma  = known_s1 ? (bank_s1 ? hi_s1 : lo_s1) : 8'd0;
		sum   = {1'b0, luma[7:1]} + {4'b0, dither};
		level = sum[7] ? 3'd7 : sum[6:4];
	end

	assign nibble = {1'b1, level};

endmodule

`default_nettype wire

/* hdl/bld_back.sv */
// Back end: luma table writes, table lookups and output word assembly.
`default_nettype none

module bld_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire bld_pkg::item_t head,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [31:0]         pixel_word,
	output logic [8:0]          line_number,
	output logic [5:0]          word_number
);

	localparam int NPIX = bld_pkg::PIXELS;

	bld_pkg::wr_t                   wr;
	logic                           advance;
	logic [bld_pkg::BANK_DEPTH-1:0] known_lo_q;
	logic [bld_pkg::BANK_DEPTH-1:0] known_hi_q;
	logic [bld_pkg::IDX_W-1:0]      pix_index [NPIX];
	logic [NPIX-1:0]                known_s1;
	logic [3:0]                     nibble [NPIX];
	logic [31:0]                    word_pack;
	logic                           vld_s1;
	logic [1:0]                     row_s1;
	logic [8:0]                     line_s1;
	logic [5:0]                     word_s1;
	logic                           out_valid_q;
	logic [31:0]                    pixel_word_q;
	logic [8:0]                     line_q;
	logic [5:0]                     word_q;

	// Move the whole back end only when the output register can take a result.
	assign advance = !out_valid_q || !out_stall;
	assign pop     = advance && q_valid;

	// Turn a popped palette command into table writes.
	always_comb begin
		wr         = '0;
		wr.addr    = head.index[bld_pkg::BANK_AW-1:0];
		wr.lo_data = head.luma;
		wr.hi_data = head.luma;
		if (pop) begin
			unique case (head.op)
				bld_pkg::CMD_PALETTE: begin
					wr.lo_en = !head.index[bld_pkg::IDX_W-1];
					wr.hi_en = head.index[bld_pkg::IDX_W-1];
				end
				bld_pkg::CMD_MIRROR: begin
					wr.lo_en   = 1'b1;
					wr.hi_en   = 1'b1;
					wr.hi_data = head.luma_half;
				end
				default: begin
					wr.lo_en = 1'b0;
					wr.hi_en = 1'b0;
				end
			endcase
		end
	end

	// Mark table entries once written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_lo_q <= '0;
			known_hi_q <= '0;
		end else begin
			if (wr.lo_en) begin
				known_lo_q[wr.addr] <= 1'b1;
			end
			if (wr.hi_en) begin
				known_hi_q[wr.addr] <= 1'b1;
			end
		end
	end

	// Gather each pixel's palette index, leftmost pixel from the plane MSBs.
	for (genvar p = 0; p < NPIX; p++) begin : g_pix
		for (genvar k = 0; k < bld_pkg::PLANES; k++) begin : g_bit
			assign pix_index[p][k] = head.planes[k][NPIX-1-p];
		end

		// Read the written flag alongside the table data.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				known_s1[p] <= 1'b0;
			end else if (advance) begin
				known_s1[p] <= pix_index[p][bld_pkg::IDX_W-1]
					? known_hi_q[pix_index[p][bld_pkg::BANK_AW-1:0]]
					: known_lo_q[pix_index[p][bld_pkg::BANK_AW-1:0]];
			end
		end

		bld_lane u_lane (
			.clk      (clk),
			.rd_en    (advance),
			.rd_index (pix_index[p]),
			.wr       (wr),
			.known_s1 (known_s1[p]),
			.dither   (bld_pkg::bayer(row_s1, 2'(p))),
			.nibble   (nibble[p])
		);

		assign word_pack[4*p +: 4] = nibble[p];
	end

	// Lookup stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= pop && (head.op == bld_pkg::CMD_RENDER);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			row_s1  <= head.dith_row;
			line_s1 <= head.line;
			word_s1 <= head.word;
		end
	end

	// Output register, held while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pixel_word_q <= word_pack;
			line_q       <= line_s1;
			word_q       <= word_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_word  = pixel_word_q;
	assign line_number = line_q;
	assign word_number = word_q;

endmodule

`default_nettype wire

/* hdl/bld_checker.sv */
// Port-level checker for the dither block and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module bld_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] pixel_word,
	input wire logic [8:0]  line_number,
	input wire logic [5:0]  word_number
);

	logic marker_ok;
	logic pos_ok;

	// Every nibble has its top bit set; words sit in the shifted active area, lines at or above its first line.
	assign marker_ok = ((pixel_word & 32'h88888888) == 32'h88888888);
	assign pos_ok    = (line_number >= 9'(bld_pkg::LINE_OFFSET))
		&& (word_number >= 6'(bld_pkg::WORD_OFFSET))
		&& (word_number < 6'(bld_pkg::WORD_OFFSET + bld_pkg::ACTIVE_WORDS));

	// No result is shown while reset is held.
	`ASSERT_ALWAYS(a_idle_in_reset, clk, !arst_n |-> !out_valid, "result valid in reset")

	// A stalled result stays offered.
	`ASSERT_RST(a_hold_valid, clk, arst_n, out_valid && out_stall |=> out_valid, "valid dropped")

	// A stalled result keeps its word.
	`ASSERT_RST(a_hold_word, clk, arst_n, out_valid && out_stall |=> $stable(pixel_word), "word moved")

	// Every pixel code carries the grey marker bit.
	`ASSERT_RST(a_marker, clk, arst_n, out_valid |-> marker_ok, "pixel code without marker")

	// Positions stay inside the shifted active area; lines are checked from below only.
	`ASSERT_RST(a_position, clk, arst_n, out_valid |-> pos_ok, "position out of frame")

endmodule

bind bitplane_luma_bayer_dither_top bld_checker u_bld_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_word  (pixel_word),
	.line_number (line_number),
	.word_number (word_number)
);

`default_nettype wire
